[hw/rtl/tsrp_pkg.sv]
// shared constants and types for the trapezoidal step-rate profile unit
`default_nettype none

package tsrp_pkg;

	localparam int RATE_W     = 20;
	localparam int ACC_W      = 24;
	localparam int MOVE_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int STEP_WIDTH_DEF = 32;

	localparam int RAD_W      = 63;
	localparam int ROOT_W     = 32;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 32;

	localparam logic [RATE_W-1:0] RATE_MAX = '1;
	localparam logic [RATE_W-1:0] ONE_HZ   = RATE_W'(16);

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_ACCEL    = 3'd1,
		PH_CRUISE   = 3'd2,
		PH_DECEL    = 3'd3,
		PH_COMPLETE = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOVE  = 2'd0,
		CFG_PEAK  = 2'd1,
		CFG_ACCEL = 2'd2,
		CFG_START = 2'd3
	} cfg_idx_t;

endpackage

`default_nettype wire

[hw/rtl/tsrp_sqrt.sv]
// two-lane pipelined integer square root, one result bit per stage
`default_nettype none

module tsrp_sqrt
	import tsrp_pkg::*;
#(
	parameter int SIDE_W = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  in_vld,
	input  wire  [RAD_W-1:0]     rad_a,
	input  wire  [RAD_W-1:0]     rad_b,
	input  wire  [SIDE_W-1:0]    side_in,
	output logic                 out_vld,
	output logic [ROOT_W-1:0]    root_a,
	output logic [ROOT_W-1:0]    root_b,
	output logic [SIDE_W-1:0]    side_out
);

	logic [RAD_W:0]    va_s   [0:SQRT_STEPS];
	logic [RAD_W:0]    ra_s   [0:SQRT_STEPS];
	logic [RAD_W:0]    vb_s   [0:SQRT_STEPS];
	logic [RAD_W:0]    rb_s   [0:SQRT_STEPS];
	logic [SIDE_W-1:0] side_s [0:SQRT_STEPS];
	logic              vld_s  [0:SQRT_STEPS];

	assign va_s[0]   = {1'b0, rad_a};
	assign vb_s[0]   = {1'b0, rad_b};
	assign ra_s[0]   = '0;
	assign rb_s[0]   = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_vld;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
		localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (RAD_W - 1 - 2 * i);
		logic [RAD_W:0] sum_a, sum_b;
		assign sum_a = ra_s[i] + BIT;
		assign sum_b = rb_s[i] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				if (va_s[i] >= sum_a) begin
					va_s[i+1] <= va_s[i] - sum_a;
					ra_s[i+1] <= (ra_s[i] >> 1) + BIT;
				end else begin
					va_s[i+1] <= va_s[i];
					ra_s[i+1] <= ra_s[i] >> 1;
				end
				if (vb_s[i] >= sum_b) begin
					vb_s[i+1] <= vb_s[i] - sum_b;
					rb_s[i+1] <= (rb_s[i] >> 1) + BIT;
				end else begin
					vb_s[i+1] <= vb_s[i];
					rb_s[i+1] <= rb_s[i] >> 1;
				end
			end
		end
	end

	assign out_vld  = vld_s[SQRT_STEPS];
	assign root_a   = ra_s[SQRT_STEPS][ROOT_W-1:0];
	assign root_b   = rb_s[SQRT_STEPS][ROOT_W-1:0];
	assign side_out = side_s[SQRT_STEPS];

endmodule

`default_nettype wire

[hw/rtl/trapezoidal_step_rate_profile_unit.sv]
// top level: trapezoidal step-rate profile, fully pipelined per step count
// pipeline: s1, s2, divider load, ramp divider, e1, e2, e3, root, output register
// throughput: one beat per cycle when not stalled; 32-stage ramp divider and 32-stage root set the depth
// a stalled output holds the whole pipeline, bubbles included; nothing is squeezed out
// reset: registers return to move 0, peak 16, accel 1, start 16; pipeline emptied
`default_nettype none

module trapezoidal_step_rate_profile_unit
	import tsrp_pkg::*;
#(
	parameter int STEP_WIDTH = STEP_WIDTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wen,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_wdata,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire  [31:0]           s_tdata,   // step_count
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [55:0]           m_tdata    // phase, target_rate, steps_left, is_triangular
);

	localparam int SW     = STEP_WIDTH;
	localparam int BASE_W = 2 * RATE_W;
	localparam int NUM_W  = BASE_W + 1;
	localparam int DEN_W  = ACC_W + 9;
	localparam int REM_W  = DEN_W + 1;
	localparam int PRD_W  = ACC_W + SW;
	localparam int SUM_RAW = PRD_W + 10;
	localparam int SUM_W  = (SUM_RAW > RAD_W) ? SUM_RAW : RAD_W;
	localparam logic [SUM_W-1:0] RAD_LIM = SUM_W'(1) << (RAD_W - 1);

	typedef struct packed {
		logic [SW-1:0]     step;
		logic [SW-1:0]     total;
		logic [ACC_W-1:0]  acc;
		logic [RATE_W-1:0] peak;
		logic [RATE_W-1:0] st;
		logic [BASE_W-1:0] base;
	} ctx_t;

	typedef struct packed {
		logic [2:0]        phase;
		logic              is_tri;
		logic [SW-1:0]     left;
		logic [RATE_W-1:0] peak;
		logic [RATE_W-1:0] st;
	} side_t;

	// configuration registers
	logic [MOVE_W-1:0] move_q;
	logic [RATE_W-1:0] peak_q;
	logic [ACC_W-1:0]  accel_q;
	logic [RATE_W-1:0] start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_q  <= '0;
			peak_q  <= RATE_W'(16);
			accel_q <= ACC_W'(1);
			start_q <= RATE_W'(16);
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MOVE:  move_q  <= cfg_wdata[MOVE_W-1:0];
				CFG_PEAK:  peak_q  <= cfg_wdata[RATE_W-1:0];
				CFG_ACCEL: accel_q <= cfg_wdata[ACC_W-1:0];
				CFG_START: start_q <= cfg_wdata[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_vld_q;
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	// s1: capture counts, clamp the start rate and replace a zero accel with 1
	logic              vld_s1;
	logic [SW-1:0]     step_s1, total_s1;
	logic [ACC_W-1:0]  acc_s1;
	logic [RATE_W-1:0] peak_s1, st_s1;
	logic [RATE_W-1:0] st_lo;
	assign st_lo = (start_q < ONE_HZ) ? ONE_HZ : start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s1  <= s_tdata[SW-1:0];
			total_s1 <= move_q[SW-1:0];
			acc_s1   <= (accel_q == '0) ? ACC_W'(1) : accel_q;
			peak_s1  <= peak_q;
			st_s1    <= (st_lo > peak_q) ? peak_q : st_lo;
		end
	end

	// s2: squares
	logic              vld_s2;
	ctx_t              ctx_s2;
	logic [BASE_W-1:0] pk2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2.step  <= step_s1;
			ctx_s2.total <= total_s1;
			ctx_s2.acc   <= acc_s1;
			ctx_s2.peak  <= peak_s1;
			ctx_s2.st    <= st_s1;
			ctx_s2.base  <= st_s1 * st_s1;
			pk2_s2       <= peak_s1 * peak_s1;
		end
	end

	// ramp divider: stage 0 loads numerator, then one quotient bit per stage
	logic              dv_vld_s [0:DIV_STEPS];
	logic [REM_W-1:0]  dv_rem_s [0:DIV_STEPS];
	logic [31:0]       dv_num_s [0:DIV_STEPS];
	logic [31:0]       dv_q_s   [0:DIV_STEPS];
	ctx_t              dv_ctx_s [0:DIV_STEPS];
	logic [NUM_W-1:0]  num_s2;
	assign num_s2 = NUM_W'(pk2_s2) - NUM_W'(ctx_s2.base) + NUM_W'({ctx_s2.acc, 8'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0] <= REM_W'(num_s2[NUM_W-1:32]);
			dv_num_s[0] <= num_s2[31:0];
			dv_q_s[0]   <= '0;
			dv_ctx_s[0] <= ctx_s2;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [REM_W-1:0] trial, den;
		assign trial = {dv_rem_s[k][REM_W-2:0], dv_num_s[k][31]};
		assign den   = REM_W'({dv_ctx_s[k].acc, 9'd0});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_ctx_s[k+1] <= dv_ctx_s[k];
				dv_num_s[k+1] <= {dv_num_s[k][30:0], 1'b0};
				if (trial >= den) begin
					dv_rem_s[k+1] <= trial - den;
					dv_q_s[k+1]   <= {dv_q_s[k][30:0], 1'b1};
				end else begin
					dv_rem_s[k+1] <= trial;
					dv_q_s[k+1]   <= {dv_q_s[k][30:0], 1'b0};
				end
			end
		end
	end

	// e1: profile shape and phase
	ctx_t          dc;
	logic [31:0]   ramp;
	logic          tri_c;
	logic [SW-1:0] up_c, down_c, left_c, nr_c;
	logic [2:0]    ph_c;
	assign dc   = dv_ctx_s[DIV_STEPS];
	assign ramp = dv_q_s[DIV_STEPS];

	always_comb begin
		tri_c  = {1'b0, ramp, 1'b0} >= 34'(dc.total);
		up_c   = tri_c ? (dc.total >> 1) : ramp[SW-1:0];
		down_c = tri_c ? (dc.total - up_c) : ramp[SW-1:0];
		left_c = (dc.step >= dc.total) ? '0 : dc.total - dc.step;
		nr_c   = '0;
		if (dc.total == '0) begin
			ph_c = PH_IDLE;
		end else if (dc.step >= dc.total) begin
			ph_c = PH_COMPLETE;
		end else if (dc.step < up_c) begin
			ph_c = PH_ACCEL;
			nr_c = dc.step;
		end else if (dc.step >= dc.total - down_c) begin
			ph_c = PH_DECEL;
			nr_c = left_c - SW'(1);
		end else begin
			ph_c = PH_CRUISE;
		end
	end

	logic              vld_e1;
	side_t             sd_e1;
	logic [SW-1:0]     up_e1, nr_e1;
	logic [ACC_W-1:0]  acc_e1;
	logic [BASE_W-1:0] base_e1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_e1 <= 1'b0;
		end else if (en) begin
			vld_e1 <= dv_vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_e1.phase  <= ph_c;
			sd_e1.is_tri <= tri_c;
			sd_e1.left   <= left_c;
			sd_e1.peak   <= dc.peak;
			sd_e1.st     <= dc.st;
			up_e1        <= up_c;
			nr_e1        <= nr_c;
			acc_e1       <= dc.acc;
			base_e1      <= dc.base;
		end
	end

	// e2: acceleration products
	logic              vld_e2;
	side_t             sd_e2;
	logic [PRD_W-1:0]  pp_e2, pr_e2;
	logic [BASE_W-1:0] base_e2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_e2 <= 1'b0;
		end else if (en) begin
			vld_e2 <= vld_e1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_e2   <= sd_e1;
			pp_e2   <= acc_e1 * up_e1;
			pr_e2   <= acc_e1 * nr_e1;
			base_e2 <= base_e1;
		end
	end

	// e3: radicands, saturated
	logic [SUM_W-1:0] sum_p, sum_r;
	assign sum_p = SUM_W'(base_e2) + (SUM_W'(pp_e2) << 9);
	assign sum_r = SUM_W'(base_e2) + (SUM_W'(pr_e2) << 9);

	logic             vld_e3;
	side_t            sd_e3;
	logic [RAD_W-1:0] radp_e3, radr_e3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_e3 <= 1'b0;
		end else if (en) begin
			vld_e3 <= vld_e2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_e3   <= sd_e2;
			radp_e3 <= (sum_p > RAD_LIM) ? RAD_LIM[RAD_W-1:0] : sum_p[RAD_W-1:0];
			radr_e3 <= (sum_r > RAD_LIM) ? RAD_LIM[RAD_W-1:0] : sum_r[RAD_W-1:0];
		end
	end

	logic              sq_vld;
	logic [ROOT_W-1:0] root_p, root_r;
	logic [$bits(side_t)-1:0] sq_side;

	tsrp_sqrt #(
		.SIDE_W($bits(side_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_e3),
		.rad_a    (radp_e3),
		.rad_b    (radr_e3),
		.side_in  (sd_e3),
		.out_vld  (sq_vld),
		.root_a   (root_p),
		.root_b   (root_r),
		.side_out (sq_side)
	);

	// final: peak recompute, clamp, output register
	side_t             fs;
	logic [RATE_W-1:0] pk_f, rate_f;
	assign fs = side_t'(sq_side);

	always_comb begin
		pk_f = fs.peak;
		if (fs.is_tri && root_p >= ROOT_W'(ONE_HZ)) begin
			pk_f = (root_p > ROOT_W'(RATE_MAX)) ? RATE_MAX : root_p[RATE_W-1:0];
		end
		case (phase_t'(fs.phase))
			PH_IDLE, PH_COMPLETE: rate_f = '0;
			PH_CRUISE:            rate_f = pk_f;
			PH_ACCEL, PH_DECEL: begin
				if (root_r < ROOT_W'(fs.st)) begin
					rate_f = fs.st;
				end else if (root_r > ROOT_W'(pk_f)) begin
					rate_f = pk_f;
				end else begin
					rate_f = root_r[RATE_W-1:0];
				end
			end
			default: rate_f = '0;
		endcase
	end

	logic [55:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= {fs.is_tri, 32'(fs.left), rate_f, fs.phase};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	a_idle_zero_rate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == PH_IDLE || m_tdata[2:0] == PH_COMPLETE)
		|-> m_tdata[22:3] == '0)
		else $error("idle or complete beat with nonzero rate");

	a_cruise_trap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == PH_CRUISE |-> !m_tdata[55])
		else $error("cruise beat in triangular profile");

	a_complete_left: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == PH_COMPLETE || m_tdata[2:0] == PH_IDLE)
		|-> m_tdata[54:23] == '0)
		else $error("steps left on finished move");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_e3) && $stable(dv_vld_s[0]))
		else $error("pipeline moved during stall");

endmodule

`default_nettype wire

[tb/sv/trapezoidal_step_rate_profile_unit_tb.sv]
// self-checking testbench for the trapezoidal step-rate profile unit
`timescale 1ns / 1ps

import tsrp_pkg::*;

typedef struct {
	phase_t      phase;
	bit [19:0]   target_rate;
	bit [31:0]   steps_left;
	bit          is_triangular;
} profile_point_t;

class profile_scoreboard;
	bit [31:0] move_steps = 0;
	bit [19:0] peak_rate = 16;
	bit [23:0] accel_rate = 1;
	bit [19:0] start_rate = 16;
	bit [63:0] ramp_up_len;
	profile_point_t expected_points[$];
	int unsigned fail_count;

	function bit [63:0] floor_root(bit [63:0] v);
		bit [63:0] res;
		bit [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// root of base + 512*a*n, radicand saturating at 2^62
	function bit [63:0] speed_at(bit [63:0] base, bit [63:0] a, bit [63:0] n);
		bit [63:0] lim;
		bit [63:0] term;
		bit [63:0] rad;
		lim = 64'd1 << 62;
		term = 512 * a;
		if (base >= lim || n > (lim - base) / term)
			rad = lim;
		else
			rad = base + term * n;
		return floor_root(rad);
	endfunction

	function void write_reg(cfg_idx_t idx, bit [31:0] val);
		case (idx)
			CFG_MOVE: move_steps = val;
			CFG_PEAK: peak_rate = val[19:0];
			CFG_ACCEL: accel_rate = val[23:0];
			CFG_START: start_rate = val[19:0];
			default: ;
		endcase
	endfunction

	function void note_step_count(bit [31:0] count);
		bit [63:0] tot, step, a, pk, st, base, ramp, up, dn, left, rate, n, p;
		profile_point_t e;
		tot = move_steps;
		step = count;
		a = (accel_rate == 0) ? 1 : accel_rate;
		pk = peak_rate;
		st = start_rate;
		if (st < 16)
			st = 16;
		if (st > pk)
			st = pk;
		base = st * st;
		ramp = (pk * pk - base + 256 * a) / (512 * a);
		up = ramp;
		dn = ramp;
		e.is_triangular = (up + dn) >= tot;
		if (e.is_triangular) begin
			up = tot / 2;
			dn = tot - up;
			p = speed_at(base, a, up);
			if (p >= 16)
				pk = (p > 64'hFFFFF) ? 64'hFFFFF : p;
		end
		ramp_up_len = up;
		left = (step >= tot) ? 0 : tot - step;
		rate = 0;
		if (tot == 0) begin
			e.phase = PH_IDLE;
		end else if (step >= tot) begin
			e.phase = PH_COMPLETE;
		end else begin
			if (step < up) begin
				e.phase = PH_ACCEL;
				n = step + 1;
			end else if (step >= tot - dn) begin
				e.phase = PH_DECEL;
				n = left;
			end else begin
				e.phase = PH_CRUISE;
				n = 0;
			end
			if (e.phase == PH_CRUISE) begin
				rate = pk;
			end else begin
				rate = speed_at(base, a, n - 1);
				if (rate < st)
					rate = st;
				if (rate > pk)
					rate = pk;
			end
		end
		e.target_rate = rate[19:0];
		e.steps_left = left[31:0];
		expected_points.push_back(e);
	endfunction

	function void check_point(bit [55:0] beat);
		profile_point_t e;
		if (expected_points.size() == 0) begin
			$error("output beat %h with nothing expected", beat);
			fail_count++;
			return;
		end
		e = expected_points.pop_front();
		if (beat[2:0] != e.phase) begin
			$error("phase: expected %0d, actual %0d", e.phase, beat[2:0]);
			fail_count++;
		end
		if (beat[22:3] != e.target_rate) begin
			$error("target_rate: expected %0d, actual %0d", e.target_rate, beat[22:3]);
			fail_count++;
		end
		if (beat[54:23] != e.steps_left) begin
			$error("steps_left: expected %0d, actual %0d", e.steps_left, beat[54:23]);
			fail_count++;
		end
		if (beat[55] != e.is_triangular) begin
			$error("is_triangular: expected %0d, actual %0d", e.is_triangular, beat[55]);
			fail_count++;
		end
	endfunction
endclass

module trapezoidal_step_rate_profile_unit_tb;
	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [31:0]           s_tdata;   // step_count
	logic                  m_tvalid;
	logic                  m_tready;
	logic [55:0]           m_tdata;   // phase, target_rate, steps_left, is_triangular

	profile_scoreboard profile_sb;
	int unsigned stall_pct;
	int unsigned quiet_cycles;

	trapezoidal_step_rate_profile_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			profile_sb.note_step_count(s_tdata);
		if (m_tvalid && m_tready)
			profile_sb.check_point(m_tdata);
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog on cycles with no beat either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic load_profile(bit [31:0] mv, bit [31:0] pk, bit [31:0] ac, bit [31:0] st);
		bit [31:0] vals [4];
		vals = '{mv, pk, ac, st};
		for (int i = 0; i < 4; i++) begin
			cfg_wen <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_wdata <= vals[i];
			profile_sb.write_reg(cfg_idx_t'(i), vals[i]);
			@(posedge clk);
		end
		cfg_wen <= 1'b0;
	endtask

	task automatic send_count(bit [31:0] v);
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_sender(int unsigned n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (profile_sb.expected_points.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic bit [31:0] pick_count();
		bit [31:0] tot;
		bit [31:0] up;
		tot = profile_sb.move_steps;
		up = profile_sb.ramp_up_len[31:0];
		case ($urandom_range(7))
			0: return $urandom();
			1: return up + $urandom_range(4) - 2;
			2: return tot - up + $urandom_range(4) - 2;
			3: return tot + $urandom_range(3) - 2;
			4: return $urandom_range(3);
			default: return (tot == 0) ? $urandom_range(50) : $urandom_range(tot + 2);
		endcase
	endfunction

	task automatic random_run(int unsigned items);
		int unsigned burst;
		while (items > 0) begin
			burst = $urandom_range(40, 1);
			while (burst > 0 && items > 0) begin
				send_count(pick_count());
				burst--;
				items--;
			end
			if ($urandom_range(3) != 0)
				idle_sender($urandom_range(6, 1));
		end
	endtask

	initial begin
		bit [31:0] mv, pk, ac, st;
		bit [31:0] corner_counts [9];
		profile_sb = new();
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		stall_pct = 0;
		quiet_cycles = 0;
		corner_counts = '{0, 1, 5, 499, 500, 998, 999, 1000, 1001};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset profile: idle move
		send_count(0);
		send_count(32'hFFFFFFFF);
		drain();

		// directed corners
		load_profile(1000, 1600, 100, 160);
		foreach (corner_counts[i])
			send_count(corner_counts[i]);
		drain();
		load_profile(32'hFFFFFFFF, 32'hFFFFF, 32'hFFFFFF, 32'hFFFFF);
		send_count(0);
		send_count(32'h7FFFFFFF);
		send_count(32'hFFFFFFFE);
		send_count(32'hFFFFFFFF);
		drain();
		load_profile(32'hFFFFFFFF, 32'hFFFFF, 0, 0);
		send_count(0);
		send_count(32'h80000000);
		send_count(32'hFFFFFFFE);
		drain();
		load_profile(7, 0, 3, 5);
		send_count(0);
		send_count(3);
		send_count(6);
		send_count(7);
		drain();
		load_profile(20, 1, 1, 32'hFFFFF);
		send_count(0);
		send_count(10);
		send_count(19);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			stall_pct = (ph % 4 == 0) ? 0 : $urandom_range(70, 10);
			mv = ($urandom_range(4) == 0) ? $urandom() : $urandom_range(3000);
			pk = (ph == 3) ? 32'hFFFFF : $urandom_range(32'hFFFFF);
			ac = (ph == 5) ? 32'hFFFFFF : (ph == 6) ? 0 : $urandom_range(32'hFFFFFF);
			st = (ph == 7) ? 32'hFFFFF : $urandom_range(3) == 0 ? $urandom_range(20)
				: $urandom_range(32'hFFFFF);
			if (ph % 3 == 1)
				ac = $urandom_range(200, 1);
			load_profile(mv, pk, ac, st);
			send_count(0);
			random_run(160);
			drain();
		end

		if (profile_sb.expected_points.size() == 0 && profile_sb.fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
